// ===== src/sstk_pkg.sv =====
// Shared types, sizes and helpers for the space-saving top-k heap tracker.
// Stand-alone package: no dependencies.
`default_nettype none

package sstk_pkg;

	// Heap size and the index widths that follow from it
	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int OCC_W    = $clog2(CAPACITY + 1);
	localparam int CH_W     = IDX_W + 1;

	localparam int KEY_W = 32;
	localparam int CNT_W = 32;

	// Result outcome codes
	typedef logic [2:0] outcome_t;
	localparam outcome_t OC_HIT   = 3'd0;
	localparam outcome_t OC_INS   = 3'd1;
	localparam outcome_t OC_REP   = 3'd2;
	localparam outcome_t OC_DUMP  = 3'd3;
	localparam outcome_t OC_EMPTY = 3'd4;

	// Update channel item
	typedef struct packed {
		logic             mode;
		logic [KEY_W-1:0] flow_key;
	} upd_item_t;

	// Result channel item
	typedef struct packed {
		logic [KEY_W-1:0] flow_out;
		logic [CNT_W-1:0] count_out;
		outcome_t         outcome;
		logic [CNT_W-1:0] update_total;
		logic             last;
	} res_item_t;

	// One heap slot
	typedef struct packed {
		logic [KEY_W-1:0] flow;
		logic [CNT_W-1:0] count;
	} entry_t;

	// Saturating increment
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

// ===== src/space_saving_topk_heap.sv =====
// Space-saving top-k flow tracker kept as an array min-heap in one RAM; needs sstk_pkg.
// Update item: accepted, then the stored entries are searched (one RAM read each), then
// sift-down levels (states SD_L then SD_R) or sift-up levels (state SU), then one result.
// Dump item: stored entries are read out in order, one result per cycle while not stalled.
// Reset clears occupancy and the update counter at once; the RAM is not cleared.
`default_nettype none

module space_saving_topk_heap (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  upd_valid,
	output logic                  upd_stall,
	input  sstk_pkg::upd_item_t   upd_item,
	output logic                  res_valid,
	input  logic                  res_stall,
	output sstk_pkg::res_item_t   res_item
);
	import sstk_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SD_L,
		ST_SD_R,
		ST_SU,
		ST_EMIT,
		ST_DUMP_RD,
		ST_DUMP_OUT
	} state_t;

	state_t             state_q;
	logic [OCC_W-1:0]   occ_q;
	logic [CNT_W-1:0]   tot_q;
	logic [KEY_W-1:0]   key_q;
	entry_t             cur_q;
	outcome_t           outcome_q;
	logic [IDX_W-1:0]   pos_q;
	logic [OCC_W-1:0]   idx_q;
	logic [IDX_W-1:0]   chk_idx_q;
	logic [CNT_W-1:0]   root_cnt_q;
	logic               best_vld_q;
	entry_t             best_q;
	res_item_t          res_q;
	logic               res_valid_q;

	// Heap storage
	entry_t             mem_q [CAPACITY];
	entry_t             rd_q;

	logic               res_free;
	logic               res_load_c;
	logic               upd_fire;
	logic               hit_c;
	logic               miss_c;
	logic               full_c;
	logic               dump_last_c;
	logic [CH_W-1:0]    left_c;
	logic [CH_W-1:0]    right_c;
	logic [CNT_W-1:0]   cmp_cnt_c;
	logic               right_ok_c;
	logic               move_c;
	entry_t             mv_ent_c;
	logic [IDX_W-1:0]   mv_idx_c;
	logic [IDX_W-1:0]   sd_p_c;
	logic [CH_W-1:0]    sd_left_c;
	logic               sd_has_left_c;
	logic [IDX_W-1:0]   par_c;
	logic [IDX_W-1:0]   su_p_c;
	logic [IDX_W-1:0]   su_par_c;
	logic               su_has_par_c;
	logic               up_move_c;
	logic [OCC_W-1:0]   idx_inc_c;
	logic [IDX_W-1:0]   ra_c;
	logic               we_c;
	logic [IDX_W-1:0]   wa_c;
	entry_t             wd_c;

	// Handshake
	assign upd_stall = (state_q != ST_IDLE);
	assign upd_fire  = upd_valid && (state_q == ST_IDLE);
	assign res_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// result register takes a new item this cycle
	assign res_load_c = res_free && ((state_q == ST_EMIT) || (state_q == ST_DUMP_OUT));

	// Search decisions: rd_q holds entry chk_idx_q
	assign hit_c  = (state_q == ST_SEARCH) && (rd_q.flow == key_q);
	assign miss_c = (state_q == ST_SEARCH) && !hit_c
		&& ((OCC_W'(chk_idx_q) + OCC_W'(1)) == occ_q);
	assign full_c = (occ_q == OCC_W'(CAPACITY));
	assign idx_inc_c   = idx_q + OCC_W'(1);
	assign dump_last_c = (idx_inc_c == occ_q);

	// Sift-down compare: best_q is the left child if smaller, rd_q the right child
	assign left_c     = {pos_q, 1'b1};
	assign right_c    = left_c + CH_W'(1);
	assign cmp_cnt_c  = best_vld_q ? best_q.count : cur_q.count;
	assign right_ok_c = (right_c < CH_W'(occ_q)) && (rd_q.count < cmp_cnt_c);
	assign move_c     = right_ok_c || best_vld_q;
	assign mv_ent_c   = right_ok_c ? rd_q : best_q;
	assign mv_idx_c   = right_ok_c ? right_c[IDX_W-1:0] : left_c[IDX_W-1:0];

	// Position at which a sift-down (re)starts, and its left child
	always_comb begin
		unique case (state_q)
			ST_SEARCH: sd_p_c = hit_c ? chk_idx_q : '0;
			ST_SD_R:   sd_p_c = mv_idx_c;
			default:   sd_p_c = pos_q;
		endcase
	end
	assign sd_left_c     = {sd_p_c, 1'b1};
	assign sd_has_left_c = (sd_left_c < CH_W'(occ_q));

	// Sift-up: rd_q holds the parent of pos_q
	assign par_c        = (pos_q - IDX_W'(1)) >> 1;
	assign up_move_c    = (rd_q.count > cur_q.count);
	assign su_p_c       = (state_q == ST_SEARCH) ? occ_q[IDX_W-1:0] : par_c;
	assign su_par_c     = (su_p_c - IDX_W'(1)) >> 1;
	assign su_has_par_c = (su_p_c != '0);

	// RAM read address and write port
	always_comb begin
		ra_c = pos_q;
		we_c = 1'b0;
		wa_c = pos_q;
		wd_c = cur_q;
		unique case (state_q)
			ST_IDLE: begin
				ra_c = '0;
			end
			ST_SEARCH: begin
				if (hit_c) begin
					ra_c = sd_left_c[IDX_W-1:0];
				end else if (miss_c && !full_c) begin
					ra_c = su_par_c;
				end else if (miss_c) begin
					ra_c = sd_left_c[IDX_W-1:0];
				end else begin
					ra_c = idx_q[IDX_W-1:0];
				end
			end
			ST_SD_L: begin
				ra_c = right_c[IDX_W-1:0];
			end
			ST_SD_R: begin
				ra_c = sd_left_c[IDX_W-1:0];
				if (move_c) begin
					we_c = 1'b1;
					wd_c = mv_ent_c;
				end
			end
			ST_SU: begin
				ra_c = su_par_c;
				if (up_move_c) begin
					we_c = 1'b1;
					wd_c = rd_q;
				end
			end
			ST_EMIT: begin
				// final placement of the moving entry
				we_c = (outcome_q != OC_EMPTY);
			end
			ST_DUMP_RD: begin
				ra_c = idx_q[IDX_W-1:0];
			end
			ST_DUMP_OUT: begin
				ra_c = (res_free && !dump_last_c) ? idx_inc_c[IDX_W-1:0]
					: idx_q[IDX_W-1:0];
			end
			default: begin
				ra_c = pos_q;
			end
		endcase
	end

	// Heap RAM, registered read
	always_ff @(posedge clk) begin
		if (we_c) begin
			mem_q[wa_c] <= wd_c;
		end
		rd_q <= mem_q[ra_c];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			tot_q       <= '0;
			res_valid_q <= 1'b0;
			key_q       <= '0;
			cur_q       <= '0;
			outcome_q   <= OC_HIT;
			pos_q       <= '0;
			idx_q       <= '0;
			chk_idx_q   <= '0;
			root_cnt_q  <= '0;
			best_vld_q  <= 1'b0;
			best_q      <= '0;
			res_q       <= '0;
		end else begin
			// result valid: set on load, cleared once taken
			if (res_load_c) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (upd_fire) begin
						key_q <= upd_item.flow_key;
						if (upd_item.mode) begin
							if (occ_q == '0) begin
								cur_q     <= '0;
								outcome_q <= OC_EMPTY;
								state_q   <= ST_EMIT;
							end else begin
								idx_q   <= '0;
								state_q <= ST_DUMP_RD;
							end
						end else begin
							tot_q <= sat_inc(tot_q);
							if (occ_q == '0) begin
								cur_q     <= '{flow: upd_item.flow_key, count: CNT_W'(1)};
								outcome_q <= OC_INS;
								pos_q     <= '0;
								occ_q     <= OCC_W'(1);
								state_q   <= ST_EMIT;
							end else begin
								// entry 0 is already being read
								chk_idx_q <= '0;
								idx_q     <= OCC_W'(1);
								state_q   <= ST_SEARCH;
							end
						end
					end
				end
				ST_SEARCH: begin
					if (chk_idx_q == '0) begin
						root_cnt_q <= rd_q.count;
					end
					if (hit_c) begin
						cur_q     <= '{flow: key_q, count: sat_inc(rd_q.count)};
						outcome_q <= OC_HIT;
						pos_q     <= chk_idx_q;
						state_q   <= sd_has_left_c ? ST_SD_L : ST_EMIT;
					end else if (miss_c && !full_c) begin
						cur_q     <= '{flow: key_q, count: CNT_W'(1)};
						outcome_q <= OC_INS;
						pos_q     <= occ_q[IDX_W-1:0];
						occ_q     <= occ_q + OCC_W'(1);
						state_q   <= su_has_par_c ? ST_SU : ST_EMIT;
					end else if (miss_c) begin
						// full: new flow takes over the minimum at the root
						cur_q     <= '{flow: key_q, count: sat_inc(root_cnt_q)};
						outcome_q <= OC_REP;
						pos_q     <= '0;
						state_q   <= sd_has_left_c ? ST_SD_L : ST_EMIT;
					end else begin
						chk_idx_q <= idx_q[IDX_W-1:0];
						idx_q     <= idx_inc_c;
					end
				end
				ST_SD_L: begin
					best_vld_q <= (rd_q.count < cur_q.count);
					best_q     <= rd_q;
					state_q    <= ST_SD_R;
				end
				ST_SD_R: begin
					if (move_c) begin
						pos_q   <= mv_idx_c;
						state_q <= sd_has_left_c ? ST_SD_L : ST_EMIT;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_SU: begin
					if (up_move_c) begin
						pos_q   <= par_c;
						state_q <= su_has_par_c ? ST_SU : ST_EMIT;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (res_free) begin
						res_q       <= '{flow_out: cur_q.flow, count_out: cur_q.count,
							outcome: outcome_q, update_total: tot_q, last: 1'b1};
						if (outcome_q == OC_EMPTY) begin
							occ_q <= '0;
							tot_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_DUMP_RD: begin
					state_q <= ST_DUMP_OUT;
				end
				ST_DUMP_OUT: begin
					if (res_free) begin
						res_q       <= '{flow_out: rd_q.flow, count_out: rd_q.count,
							outcome: OC_DUMP, update_total: tot_q, last: dump_last_c};
						if (dump_last_c) begin
							occ_q   <= '0;
							tot_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_inc_c;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== test/tb_space_saving_topk_heap.sv =====
// Testbench for space_saving_topk_heap: drives update and dump items, keeps its own
// copy of the min-heap tracker and checks every result item field by field.
// Depends on sstk_pkg (item types, outcome codes, sizes) and the block itself.
`timescale 1ns / 1ps

module tb_space_saving_topk_heap;
	import sstk_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      upd_valid = 1'b0;
	logic      upd_stall;
	upd_item_t upd_item  = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res_item;

	// no random idling on either side while set
	bit quiet_stretch = 1'b0;
	int fail_count    = 0;
	int idle_cycles   = 0;
	int n_updates     = 0;
	int n_dumps       = 0;
	int n_checked     = 0;
	int outcome_tally[8];

	// tracker state as the block should hold it
	entry_t           tracked[CAPACITY];
	int               tracked_n = 0;
	logic [CNT_W-1:0] packets_since_clear = '0;
	res_item_t        awaited_results[$];

	space_saving_topk_heap dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd_valid(upd_valid),
		.upd_stall(upd_stall),
		.upd_item (upd_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------- prediction

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic void swap_entries(input int a, input int b);
		entry_t t;
		t = tracked[a];
		tracked[a] = tracked[b];
		tracked[b] = t;
	endfunction

	// move an entry toward the leaves while a child is strictly smaller; left wins ties
	function automatic void sink_entry(input int pos);
		int lo;
		while (2 * pos + 1 < tracked_n) begin
			lo = pos;
			if (tracked[2 * pos + 1].count < tracked[lo].count)
				lo = 2 * pos + 1;
			if (2 * pos + 2 < tracked_n && tracked[2 * pos + 2].count < tracked[lo].count)
				lo = 2 * pos + 2;
			if (lo == pos)
				break;
			swap_entries(pos, lo);
			pos = lo;
		end
	endfunction

	// move an entry toward the root while its parent is strictly larger
	function automatic void raise_entry(input int pos);
		while (pos > 0 && tracked[(pos - 1) / 2].count > tracked[pos].count) begin
			swap_entries(pos, (pos - 1) / 2);
			pos = (pos - 1) / 2;
		end
	endfunction

	// update the tracker copy for one accepted item and queue the results it causes
	function automatic void apply_item(input upd_item_t it);
		res_item_t r;
		int        found;
		if (it.mode) begin
			n_dumps++;
			if (tracked_n == 0) begin
				r = '{flow_out: '0, count_out: '0, outcome: OC_EMPTY,
					update_total: packets_since_clear, last: 1'b1};
				awaited_results.push_back(r);
				outcome_tally[OC_EMPTY]++;
			end
			for (int i = 0; i < tracked_n; i++) begin
				r = '{flow_out: tracked[i].flow, count_out: tracked[i].count, outcome: OC_DUMP,
					update_total: packets_since_clear, last: (i == tracked_n - 1)};
				awaited_results.push_back(r);
				outcome_tally[OC_DUMP]++;
			end
			tracked_n = 0;
			packets_since_clear = '0;
			return;
		end
		n_updates++;
		packets_since_clear = count_up(packets_since_clear);
		found = -1;
		for (int i = 0; i < tracked_n; i++)
			if (found < 0 && tracked[i].flow == it.flow_key)
				found = i;
		r.flow_out     = it.flow_key;
		r.update_total = packets_since_clear;
		r.last         = 1'b1;
		if (found >= 0) begin
			tracked[found].count = count_up(tracked[found].count);
			r.count_out = tracked[found].count;
			r.outcome   = OC_HIT;
			sink_entry(found);
		end else if (tracked_n < CAPACITY) begin
			tracked[tracked_n] = '{flow: it.flow_key, count: CNT_W'(1)};
			r.count_out = CNT_W'(1);
			r.outcome   = OC_INS;
			tracked_n++;
			raise_entry(tracked_n - 1);
		end else begin
			// heap full: the minimum gives up its slot to the new flow
			tracked[0].flow  = it.flow_key;
			tracked[0].count = count_up(tracked[0].count);
			r.count_out = tracked[0].count;
			r.outcome   = OC_REP;
			sink_entry(0);
		end
		outcome_tally[r.outcome]++;
		awaited_results.push_back(r);
	endfunction

	// ---------------------------------------------------------------- driving

	// present one item at a falling edge, hold it until accepted, then predict
	task automatic send_item(input logic mode, input logic [KEY_W-1:0] key);
		@(negedge clk);
		while (!quiet_stretch && $urandom_range(0, 99) < 12) begin
			upd_valid <= 1'b0;
			@(negedge clk);
		end
		upd_valid <= 1'b1;
		upd_item  <= '{mode: mode, flow_key: key};
		do @(posedge clk); while (upd_stall);
		apply_item(upd_item);
	endtask

	// result side stalls at random
	always @(negedge clk)
		res_stall <= !quiet_stretch && ($urandom_range(0, 99) < 12);

	// ---------------------------------------------------------------- checking

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (awaited_results.size() == 0) begin
				$error("result item with none expected: flow_out %0h outcome %0d",
					res_item.flow_out, res_item.outcome);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				check_field("flow_out", want.flow_out, res_item.flow_out);
				check_field("count_out", want.count_out, res_item.count_out);
				check_field("outcome", want.outcome, res_item.outcome);
				check_field("update_total", want.update_total, res_item.update_total);
				check_field("last", want.last, res_item.last);
				n_checked++;
			end
		end
	end

	// cycles since either channel last moved an item
	always @(posedge clk)
		if (!arst_n || (upd_valid && !upd_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;

	initial begin : watchdog
		wait (idle_cycles >= IDLE_LIMIT);
		$display("FAIL space_saving_topk_heap");
		$finish;
	end

	// ---------------------------------------------------------------- tests

	// dump straight after reset
	task automatic test_empty_dump;
		send_item(1'b1, '0);
	endtask

	// field extremes, hits, a dump and an empty dump, then the equal-children tie
	task automatic test_directed;
		send_item(1'b0, '0);
		send_item(1'b0, '1);
		send_item(1'b0, '0);
		send_item(1'b0, 32'h5555_5555);
		send_item(1'b0, 32'hAAAA_AAAA);
		send_item(1'b0, 32'h5555_5555);
		send_item(1'b1, 32'h1234_5678);
		send_item(1'b1, '1);
		// three count-1 entries, then the root gets hit: both children equal
		send_item(1'b0, 32'h0000_00A0);
		send_item(1'b0, 32'h0000_00A1);
		send_item(1'b0, 32'h0000_00A2);
		send_item(1'b0, 32'h0000_00A0);
		send_item(1'b1, '0);
	endtask

	// fill every slot, hit a leaf, then push new flows through the root
	task automatic test_full_heap;
		for (int i = 0; i < CAPACITY; i++)
			send_item(1'b0, 32'h0F10_0000 | i);
		send_item(1'b0, 32'h0F10_0000 | (CAPACITY - 1));
		for (int i = 0; i < 4; i++)
			send_item(1'b0, 32'hE200_0000 | i);
		send_item(1'b0, 32'hE200_0000);
		send_item(1'b1, 32'h8000_0001);
	endtask

	// runs over a skewed flow pool, each closed by a dump; some pools overflow the heap
	task automatic test_random;
		logic [KEY_W-1:0] pool[48];
		int               pool_n;
		int               run_len;
		for (int phase = 0; phase < 6; phase++) begin
			quiet_stretch = (phase == 2);
			pool_n  = (phase % 3 == 0) ? $urandom_range(CAPACITY + 1, 48) : $urandom_range(1, 24);
			run_len = $urandom_range(15, 35);
			foreach (pool[k])
				pool[k] = $urandom;
			for (int j = 0; j < run_len; j++) begin
				case ($urandom_range(0, 19))
					0: send_item(1'b0, $urandom);
					1: send_item(1'b1, $urandom);
					default: send_item(1'b0, pool[$urandom_range(0, $urandom_range(0, pool_n - 1))]);
				endcase
			end
			send_item(1'b1, $urandom);
		end
		quiet_stretch = 1'b0;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_dump();
		test_directed();
		test_full_heap();
		test_random();

		@(negedge clk);
		upd_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d flow updates and %0d dumps: %0d hits, %0d inserts, %0d min replacements.",
			n_updates, n_dumps, outcome_tally[OC_HIT], outcome_tally[OC_INS], outcome_tally[OC_REP]);
		$display("Checked %0d result items (%0d dumped entries, %0d empty dumps), %0d mismatches.",
			n_checked, outcome_tally[OC_DUMP], outcome_tally[OC_EMPTY], fail_count);
		if (fail_count == 0 && awaited_results.size() == 0)
			$display("PASS space_saving_topk_heap");
		else
			$display("FAIL space_saving_topk_heap");
		$finish;
	end

endmodule

// ===== space_saving_topk_heap.f =====
src/sstk_pkg.sv
src/space_saving_topk_heap.sv
test/tb_space_saving_topk_heap.sv
